[hw/rtl/g2l_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// g2l_pkg: shared types and constants for the gregorian to lunar day block
// request and response payloads, lunar year table and month offset table
// ----------------------------------------------------------------------------
package g2l_pkg;

    localparam int BASE_YEAR       = 2019;
    localparam int LEAP_REF_YEAR   = 2016;
    localparam int BASE_DAY_OFFSET = 35;
    localparam int DAYS_PER_YEAR   = 365;
    localparam int SHORT_MONTH     = 29;
    localparam int BASE_MONTHS     = 12;
    localparam int ROM_WORDS       = 81;
    localparam int ROM_IDX_W       = 7;
    localparam int COUNT_W         = 20;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
    } t_req;

    typedef struct packed {
        logic [4:0] lunar_day;
        logic       out_of_range;
    } t_rsp;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] remain;
    } t_walk_cmd;

    typedef struct packed {
        logic       done;
        logic       found;
        logic [4:0] day;
    } t_walk_sts;

    // days in the year before the first of each month, non-leap
    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        begin
            case (idx)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd59;
                4'd3:    d = 9'd90;
                4'd4:    d = 9'd120;
                4'd5:    d = 9'd151;
                4'd6:    d = 9'd181;
                4'd7:    d = 9'd212;
                4'd8:    d = 9'd243;
                4'd9:    d = 9'd273;
                4'd10:   d = 9'd304;
                4'd11:   d = 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

    // bit 0: thirteen-month year, bit k: month k has 30 days
    function automatic logic [15:0] lunar_rom_word(input logic [ROM_IDX_W-1:0] idx);
        logic [15:0] w;
        begin
            case (idx)
                7'd0:  w = 16'd6442;
                7'd1:  w = 16'd10845;
                7'd2:  w = 16'd2732;
                7'd3:  w = 16'd5482;
                7'd4:  w = 16'd11109;
                7'd5:  w = 16'd3492;
                7'd6:  w = 16'd7499;
                7'd7:  w = 16'd3658;
                7'd8:  w = 16'd3222;
                7'd9:  w = 16'd6447;
                7'd10: w = 16'd6486;
                7'd11: w = 16'd2740;
                7'd12: w = 16'd5549;
                7'd13: w = 16'd5842;
                7'd14: w = 16'd11941;
                7'd15: w = 16'd5796;
                7'd16: w = 16'd5706;
                7'd17: w = 16'd13463;
                7'd18: w = 16'd5270;
                7'd19: w = 16'd2390;
                7'd20: w = 16'd2743;
                7'd21: w = 16'd2906;
                7'd22: w = 16'd5844;
                7'd23: w = 16'd13989;
                7'd24: w = 16'd6948;
                7'd25: w = 16'd14923;
                7'd26: w = 16'd6730;
                7'd27: w = 16'd5290;
                7'd28: w = 16'd10587;
                7'd29: w = 16'd2412;
                7'd30: w = 16'd2922;
                7'd31: w = 16'd6997;
                7'd32: w = 16'd7570;
                7'd33: w = 16'd15653;
                7'd34: w = 16'd7460;
                7'd35: w = 16'd6732;
                7'd36: w = 16'd5293;
                7'd37: w = 16'd5294;
                7'd38: w = 16'd2476;
                7'd39: w = 16'd3499;
                7'd40: w = 16'd3754;
                7'd41: w = 16'd3722;
                7'd42: w = 16'd7463;
                7'd43: w = 16'd3366;
                7'd44: w = 16'd10839;
                7'd45: w = 16'd2646;
                7'd46: w = 16'd5302;
                7'd47: w = 16'd10933;
                7'd48: w = 16'd2772;
                7'd49: w = 16'd5834;
                7'd50: w = 16'd11925;
                7'd51: w = 16'd5780;
                7'd52: w = 16'd13611;
                7'd53: w = 16'd5418;
                7'd54: w = 16'd2650;
                7'd55: w = 16'd5467;
                7'd56: w = 16'd5482;
                7'd57: w = 16'd2900;
                7'd58: w = 16'd5963;
                7'd59: w = 16'd6986;
                7'd60: w = 16'd6804;
                7'd61: w = 16'd14635;
                7'd62: w = 16'd6444;
                7'd63: w = 16'd12957;
                7'd64: w = 16'd2732;
                7'd65: w = 16'd5482;
                7'd66: w = 16'd11109;
                7'd67: w = 16'd3492;
                7'd68: w = 16'd7498;
                7'd69: w = 16'd7317;
                7'd70: w = 16'd3350;
                7'd71: w = 16'd6447;
                7'd72: w = 16'd2390;
                7'd73: w = 16'd2742;
                7'd74: w = 16'd5549;
                7'd75: w = 16'd5844;
                7'd76: w = 16'd3748;
                7'd77: w = 16'd11851;
                7'd78: w = 16'd5770;
                7'd79: w = 16'd5398;
                7'd80: w = 16'd10551;
                default: w = 16'd0;
            endcase
            return w;
        end
    endfunction

endpackage : g2l_pkg
`default_nettype wire

[hw/rtl/gregorian_to_lunar_day.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_to_lunar_day: gregorian date to chinese lunar day of month
// top level with request handshake, day count stage and result register
// ----------------------------------------------------------------------------
// Takes one request at a time. The day count from lunar new year 2019-02-05
// is formed in the prep and sum states. The month walker then compares the
// count against each lunar month in turn, including the month the date falls
// in. The result register is then loaded. Invalid dates finish from the prep
// state and dates before the base from the sum state. o_req_ready is low from
// acceptance until the result has been taken on the response side.
// ----------------------------------------------------------------------------
module gregorian_to_lunar_day #(
    parameter int TABLE_YEARS = 81
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_req_valid,
    output logic           o_req_ready,
    input  g2l_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  wire            i_rsp_ready,
    output g2l_pkg::t_rsp  o_rsp
);
    import g2l_pkg::*;

    localparam int YEARS_EFF = (TABLE_YEARS < ROM_WORDS) ? TABLE_YEARS : ROM_WORDS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]         r_state, n_state;
    t_req               r_req, n_req;
    logic [COUNT_W-1:0] r_base, n_base;
    logic [10:0]        r_add, n_add;
    logic               r_fix, n_fix;
    t_rsp               r_rsp, n_rsp;
    t_walk_cmd          walk_cmd;
    t_walk_sts          walk_sts;

    logic               bad;
    logic [11:0]        yoff;
    logic [11:0]        loff;
    logic [COUNT_W-1:0] sum;
    logic [COUNT_W-1:0] lim;

    always_comb begin
        bad  = (r_req.month < 4'd1) || (r_req.month > 4'd12) ||
               (r_req.day_of_month == 5'd0) || (r_req.year < 12'(BASE_YEAR));
        yoff = r_req.year - 12'(BASE_YEAR);
        loff = r_req.year - 12'(LEAP_REF_YEAR);
        sum  = r_base + COUNT_W'(r_add);
        lim  = COUNT_W'(BASE_DAY_OFFSET) + COUNT_W'(r_fix);
    end

    always_comb begin
        n_state         = r_state;
        n_req           = r_req;
        n_base          = r_base;
        n_add           = r_add;
        n_fix           = r_fix;
        n_rsp           = r_rsp;
        walk_cmd.start  = 1'b0;
        walk_cmd.remain = sum - lim;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_base = COUNT_W'(yoff) * COUNT_W'(DAYS_PER_YEAR);
                n_add  = 11'(loff[11:2]) +
                         11'(days_before_month(r_req.month - 4'd1)) +
                         11'(r_req.day_of_month);
                // current year's leap day not yet reached in jan and feb
                n_fix  = (r_req.year[1:0] == 2'b00) && (r_req.month < 4'd3);
                if (bad) begin
                    n_rsp   = '{lunar_day: 5'd0, out_of_range: 1'b1};
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sum <= lim) begin
                    n_rsp   = '{lunar_day: 5'd0, out_of_range: 1'b1};
                    n_state = ST_OUT;
                end else begin
                    walk_cmd.start = 1'b1;
                    n_state        = ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_sts.done) begin
                    n_rsp.lunar_day    = walk_sts.found ? walk_sts.day : 5'd0;
                    n_rsp.out_of_range = !walk_sts.found;
                    n_state            = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_rsp_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_req  <= n_req;
        r_base <= n_base;
        r_add  <= n_add;
        r_fix  <= n_fix;
        r_rsp  <= n_rsp;
    end

    g2l_walk #(
        .YEARS (YEARS_EFF)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (walk_cmd),
        .o_sts   (walk_sts)
    );

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = (r_state == ST_OUT);
    assign o_rsp       = r_rsp;

endmodule : gregorian_to_lunar_day
`default_nettype wire

[hw/rtl/g2l_walk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// g2l_walk: lunar month walker
// subtracts one lunar month length per cycle from the day count until the
// remainder fits in the current month or the table runs out
// ----------------------------------------------------------------------------
module g2l_walk #(
    parameter int YEARS = 81
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  g2l_pkg::t_walk_cmd  i_cmd,
    output g2l_pkg::t_walk_sts  o_sts
);
    import g2l_pkg::*;

    localparam int LY_W = (YEARS > 1) ? $clog2(YEARS) : 1;

    logic               r_busy, n_busy;
    logic [COUNT_W-1:0] r_remain, n_remain;
    logic [LY_W-1:0]    r_ly, n_ly;
    logic [3:0]         r_k, n_k;
    t_walk_sts          r_sts, n_sts;

    logic [15:0]        word;
    logic [3:0]         months;
    logic [4:0]         len;

    always_comb begin
        word   = lunar_rom_word(ROM_IDX_W'(r_ly));
        months = 4'(BASE_MONTHS) + {3'b000, word[0]};
        len    = 5'(SHORT_MONTH) + {4'b0000, word[r_k]};
    end

    always_comb begin
        n_busy      = r_busy;
        n_remain    = r_remain;
        n_ly        = r_ly;
        n_k         = r_k;
        n_sts       = r_sts;
        n_sts.done  = 1'b0;
        if (i_cmd.start) begin
            n_busy   = 1'b1;
            n_remain = i_cmd.remain;
            n_ly     = '0;
            n_k      = 4'd1;
        end else if (r_busy) begin
            if (r_remain <= COUNT_W'(len)) begin
                n_busy      = 1'b0;
                n_sts.done  = 1'b1;
                n_sts.found = 1'b1;
                n_sts.day   = r_remain[4:0];
            end else begin
                n_remain = r_remain - COUNT_W'(len);
                if (r_k == months) begin
                    n_k = 4'd1;
                    if (r_ly == LY_W'(YEARS - 1)) begin
                        // ran off the end of the table
                        n_busy      = 1'b0;
                        n_sts.done  = 1'b1;
                        n_sts.found = 1'b0;
                        n_sts.day   = 5'd0;
                    end else begin
                        n_ly = r_ly + LY_W'(1);
                    end
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_sts.done <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_sts.done <= n_sts.done;
        end
        r_remain    <= n_remain;
        r_ly        <= n_ly;
        r_k         <= n_k;
        r_sts.found <= n_sts.found;
        r_sts.day   <= n_sts.day;
    end

    assign o_sts = r_sts;

endmodule : g2l_walk
`default_nettype wire
